// File: src/tplr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tplr_pkg;
   localparam int HistDepth = 6;
   localparam int MinSamples = 3;
   localparam int CooldownLength = 2;
   localparam int CntW = $clog2(HistDepth + 1);
   localparam int CoolW = (CooldownLength > 1) ? $clog2(CooldownLength + 1) : 1;
   localparam int IdxW = (HistDepth > 1) ? $clog2(HistDepth) : 1;
   // weighted sum up to 127*W, W <= 21
   localparam int SumW = 16;
   localparam int QuoW = 8;

   localparam logic [1:0] MODE_MAX = 2'd1;
   localparam logic [1:0] MODE_REG = 2'd2;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_TARGET = 3'd1;
   localparam logic [2:0] REG_PMIN = 3'd2;
   localparam logic [2:0] REG_PMAX = 3'd3;
   localparam logic [2:0] REG_INIT = 3'd4;

   localparam logic [2:0] ACT_IDLE = 3'd0;
   localparam logic [2:0] ACT_MAX = 3'd1;
   localparam logic [2:0] ACT_BRAKE = 3'd2;
   localparam logic [2:0] ACT_STEP = 3'd3;
   localparam logic [2:0] ACT_COOL = 3'd4;
   localparam logic [2:0] ACT_DEAD = 3'd5;
   localparam logic [2:0] ACT_FEW = 3'd6;
   localparam logic [2:0] ACT_CLAMP = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TAKE, ST_SUM, ST_DIV1, ST_DECIDE, ST_DIV2, ST_FINISH, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;      // latch request, clear accumulators
      logic take;       // push sample into history
      logic sum_step;   // accumulate one history entry
      logic div_start;  // start divider (0 avg, 1 step)
      logic div_sel;
      logic div_step;
      logic decide;     // evaluate brake/deadband
      logic finish;     // apply step result
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic sum_done;
      logic div_done;
      logic need_div;   // decide needs the step divider
   } sts_type;
endpackage
`default_nettype wire

// File: src/tplr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tplr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_fire,
   input  wire logic               out_free,
   input  wire tplr_pkg::sts_type  sts,
   output tplr_pkg::cmd_type       cmd,
   output logic                    busy
);
   tplr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tplr_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != tplr_pkg::ST_IDLE);
      case (state_ff)
         tplr_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd.start = 1'b1;
               state_in = tplr_pkg::ST_TAKE;
            end
         end
         tplr_pkg::ST_TAKE: begin
            cmd.take = 1'b1;
            state_in = tplr_pkg::ST_SUM;
         end
         tplr_pkg::ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_done) begin
               cmd.div_start = 1'b1;
               state_in = tplr_pkg::ST_DIV1;
            end
         end
         tplr_pkg::ST_DIV1: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = tplr_pkg::ST_DECIDE;
         end
         tplr_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel = 1'b1;
               state_in = tplr_pkg::ST_DIV2;
            end else begin
               state_in = tplr_pkg::ST_OUT;
            end
         end
         tplr_pkg::ST_DIV2: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = tplr_pkg::ST_FINISH;
         end
         tplr_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = tplr_pkg::ST_OUT;
         end
         tplr_pkg::ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = tplr_pkg::ST_IDLE;
            end
         end
         default: state_in = tplr_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: src/tplr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tplr_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tplr_pkg::cmd_type cmd,
   output tplr_pkg::sts_type      sts,
   input  wire logic              csr_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [9:0]        csr_data,
   input  wire logic [6:0]        in_temp,
   input  wire logic              in_valid,
   output logic                   res_change,
   output logic [9:0]             res_power,
   output logic [2:0]             res_action,
   output logic [6:0]             res_avg
);
   localparam int SW = tplr_pkg::SumW;
   localparam int QW = tplr_pkg::QuoW;
   localparam int CW = tplr_pkg::CntW;
   localparam int KW = tplr_pkg::CoolW;

   logic [1:0] mode_ff;
   logic [6:0] target_ff;
   logic [9:0] pmin_ff, pmax_ff;
   logic [6:0] hist_ff [tplr_pkg::HistDepth];
   logic [CW-1:0] count_ff;
   logic [KW-1:0] cool_ff;
   logic [9:0] power_ff;
   logic [6:0] temp_ff;
   logic valid_ff;
   logic [CW-1:0] idx_ff;
   logic [SW-1:0] s_ff, w_ff;
   logic [SW+2:0] rem_ff, dvs_ff;
   logic [QW-1:0] quo_ff;
   logic [3:0] dcnt_ff;
   logic [6:0] avg_ff;
   logic [2:0] act_ff;
   logic chg_ff, neg_ff;

   logic brake_ok, take_ok;
   logic [10:0] brake_next;
   logic signed [SW+3:0] err;
   logic [SW+2:0] mag, lw;
   logic [9:0] res_power_next;

   assign take_ok = valid_ff && (mode_ff == tplr_pkg::MODE_REG);
   assign lw = (SW+3)'(temp_ff) * (SW+3)'(w_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0; target_ff <= 7'd70; pmin_ff <= 10'd100;
         pmax_ff <= 10'd400; power_ff <= 10'd150;
         count_ff <= '0; cool_ff <= '0;
      end else begin
         if (csr_en) begin
            case (csr_index)
               tplr_pkg::REG_MODE: begin
                  mode_ff <= csr_data[1:0]; count_ff <= '0; cool_ff <= '0;
               end
               tplr_pkg::REG_TARGET: begin
                  target_ff <= csr_data[6:0]; count_ff <= '0; cool_ff <= '0;
               end
               tplr_pkg::REG_PMIN: pmin_ff <= csr_data;
               tplr_pkg::REG_PMAX: pmax_ff <= csr_data;
               tplr_pkg::REG_INIT: power_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.take && take_ok && count_ff < CW'(tplr_pkg::HistDepth))
            count_ff <= count_ff + 1'b1;
         if (cmd.decide) begin
            if (!valid_ff) ;
            else if (mode_ff == tplr_pkg::MODE_MAX) power_ff <= pmax_ff;
            else if (take_ok) begin
               if (brake_ok) begin
                  power_ff <= brake_next[9:0];
                  cool_ff <= KW'(tplr_pkg::CooldownLength);
               end else if (count_ff >= CW'(tplr_pkg::MinSamples) && cool_ff != '0)
                  cool_ff <= cool_ff - 1'b1;
            end
         end
         if (cmd.finish && res_power_next != power_ff) begin
            power_ff <= res_power_next;
            cool_ff <= KW'(tplr_pkg::CooldownLength);
         end
      end
   end

   // history shift, sample push in the take cycle
   always_ff @(posedge clock) begin
      if (cmd.take && take_ok) begin
         if (count_ff < CW'(tplr_pkg::HistDepth))
            hist_ff[count_ff[tplr_pkg::IdxW-1:0]] <= temp_ff;
         else begin
            for (int i = 0; i < tplr_pkg::HistDepth - 1; i++) hist_ff[i] <= hist_ff[i+1];
            hist_ff[tplr_pkg::HistDepth-1] <= temp_ff;
         end
      end
   end

   // brake evaluation
   logic [7:0] over;
   logic [6:0] bstep;
   always_comb begin
      over = {1'b0, temp_ff} - {1'b0, target_ff};
      if (over[7] || over < 8'd2) bstep = 7'd0;
      else if (over * 3 < 5) bstep = 7'd5;
      else if (over > 8'd10) bstep = 7'd30;
      else bstep = 7'(over * 3);
      if ({1'b0, power_ff} < 11'(bstep) + 11'(pmin_ff)) brake_next = {1'b0, pmin_ff};
      else brake_next = {1'b0, power_ff} - 11'(bstep);
      brake_ok = (bstep != 0) && (brake_next < {1'b0, power_ff});
   end

   // error numerator
   always_comb begin
      logic [SW+2:0] e;
      if (lw > (SW+3)'(s_ff)) e = lw + (SW+3)'(s_ff);
      else e = (SW+3)'(s_ff) << 1;
      err = $signed({1'b0, e})
            - $signed({1'b0, (SW+3)'(target_ff) * (SW+3)'(w_ff) * (SW+3)'(2)});
      mag = err[SW+3] ? (SW+3)'(-err) : err[SW+2:0];
   end

   // step apply
   always_comb begin
      logic [QW-1:0] st;
      logic [11:0] nx;
      st = (quo_ff < 5) ? QW'(5) : (quo_ff > 30) ? QW'(30) : quo_ff;
      if (neg_ff) nx = (12'(power_ff) < 12'(st)) ? 12'd0 : 12'(power_ff) - 12'(st);
      else nx = 12'(power_ff) + 12'(st);
      // negative result below any power_min clamps up to power_min
      if (neg_ff && 12'(power_ff) < 12'(st)) nx = 12'd0;
      if (nx > 12'(pmax_ff)) nx = 12'(pmax_ff);
      if (nx < 12'(pmin_ff)) nx = 12'(pmin_ff);
      res_power_next = nx[9:0];
   end

   assign sts.sum_done = (idx_ff >= count_ff);
   assign sts.div_done = (dcnt_ff == 4'd0);
   assign sts.need_div = take_ok && !brake_ok && count_ff >= CW'(tplr_pkg::MinSamples)
                         && cool_ff == '0 && 2 * (SW+4)'(mag) > 6 * (SW+4)'(w_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         temp_ff <= in_temp; valid_ff <= in_valid;
         idx_ff <= '0; s_ff <= '0; w_ff <= '0; chg_ff <= 1'b0; act_ff <= tplr_pkg::ACT_IDLE;
      end
      if (cmd.sum_step && !sts.sum_done) begin
         s_ff <= s_ff + SW'(hist_ff[idx_ff[tplr_pkg::IdxW-1:0]]) * SW'(idx_ff + 1'b1);
         w_ff <= w_ff + SW'(idx_ff + 1'b1);
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.div_start) begin
         dcnt_ff <= 4'(QW);
         quo_ff <= '0;
         if (cmd.div_sel) begin
            rem_ff <= (SW+3)'(5 * mag); dvs_ff <= (SW+3)'(w_ff) << 2;
         end else begin
            rem_ff <= (SW+3)'(s_ff); dvs_ff <= (SW+3)'(w_ff);
         end
      end else if (cmd.div_step && dcnt_ff != 0) begin
         if ((SW+3+QW)'(rem_ff) >= ((SW+3+QW)'(dvs_ff) << (dcnt_ff - 4'd1))) begin
            rem_ff <= (SW+3)'((SW+3+QW)'(rem_ff) - ((SW+3+QW)'(dvs_ff) << (dcnt_ff - 4'd1)));
            quo_ff[3'(dcnt_ff - 4'd1)] <= 1'b1;
         end
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      if (cmd.decide) begin
         avg_ff <= (w_ff == 0) ? 7'd0 : quo_ff[6:0];
         neg_ff <= !err[SW+3];
         if (!valid_ff) act_ff <= tplr_pkg::ACT_IDLE;
         else if (mode_ff == tplr_pkg::MODE_MAX) begin
            act_ff <= tplr_pkg::ACT_MAX; chg_ff <= (power_ff != pmax_ff);
         end else if (!take_ok) act_ff <= tplr_pkg::ACT_IDLE;
         else if (brake_ok) begin
            act_ff <= tplr_pkg::ACT_BRAKE; chg_ff <= 1'b1;
         end else if (count_ff < CW'(tplr_pkg::MinSamples)) act_ff <= tplr_pkg::ACT_FEW;
         else if (cool_ff != '0) act_ff <= tplr_pkg::ACT_COOL;
         else if (sts.need_div) act_ff <= tplr_pkg::ACT_STEP;
         else act_ff <= tplr_pkg::ACT_DEAD;
      end
      if (cmd.finish) begin
         if (res_power_next == power_ff) act_ff <= tplr_pkg::ACT_CLAMP;
         else chg_ff <= 1'b1;
      end
   end

   assign res_change = chg_ff;
   assign res_power = power_ff;
   assign res_action = act_ff;
   assign res_avg = avg_ff;
endmodule
`default_nettype wire

// File: src/thermal_power_limit_regulator.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a request is taken in idle, then passes take, history sum, average divide and
// decide, plus a second divide and finish when a proportional step is computed, then output.
// Throughput: one request at a time; the next request is taken only once the last response
// is loaded, so it waits on the history sum and the bit-serial divider, and on rsp_tready
// while the response register is still full.
// Reset: synchronous, active high; registers take their documented defaults,
// history fill and cooldown clear, current power loads the initial power.
module thermal_power_limit_regulator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [6:0] temp
   input  wire logic        req_tuser,   // temp_valid
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [0] power_change, [10:1] new_power, [13:11] action
   output logic [6:0]       rsp_tuser,   // avg_temp
   input  wire logic        csr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_data
);
   tplr_pkg::cmd_type cmd;
   tplr_pkg::sts_type sts;
   logic busy, req_fire, out_free;
   logic chg, vld_ff;
   logic [9:0] pw;
   logic [2:0] act;
   logic [6:0] avg;
   logic [15:0] data_ff;
   logic [6:0] user_ff;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !vld_ff || rsp_tready;

   tplr_ctrl u_ctrl (.clock, .reset, .req_fire, .out_free, .sts, .cmd, .busy);

   tplr_datapath u_dp (
      .clock, .reset, .cmd, .sts, .csr_en, .csr_index, .csr_data,
      .in_temp(req_tdata[6:0]), .in_valid(req_tuser),
      .res_change(chg), .res_power(pw), .res_action(act), .res_avg(avg)
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (cmd.out_load) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         data_ff <= {2'b00, act, pw, chg};
         user_ff <= avg;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("request taken while busy");
   a_load_once: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> !busy) else $error("controller stayed busy after load");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("response changed");
endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   // mode codes the package leaves unnamed
   localparam logic [1:0] MODE_OFF = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   // register indexes past the last register, ignored by the block
   localparam logic [2:0] REG_VOID_LO = 3'd5;
   localparam logic [2:0] REG_VOID_HI = 3'd7;
   // brake and step constants of the control law
   localparam int StepLo = 5;
   localparam int StepHi = 30;
   localparam int BrakeOvershoot = 2;
   localparam int BrakeGain = 3;
   // settle time after the last response, before a register write
   localparam int SettleCycles = 40;
   localparam int ExpDepth = 2048;

   typedef struct {
      logic       change;
      logic [9:0] power;
      logic [2:0] action;
      logic [6:0] avg;
   } limit_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [6:0] temp
   logic        req_tuser = 1'b0;  // temp_valid
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [0] power_change, [10:1] new_power, [13:11] action
   logic [6:0]  rsp_tuser;         // avg_temp
   logic        csr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_data = '0;

   thermal_power_limit_regulator u_top (.*);

   always #5 clock = ~clock;

   // shadow of the regulator's registers and state
   logic [1:0] mdl_mode;
   int         mdl_target, mdl_pmin, mdl_pmax;
   logic [6:0] mdl_hist [tplr_pkg::HistDepth];
   int         mdl_fill, mdl_cool, mdl_power;

   // expected responses, oldest at exp_rd
   limit_result_type exp_q [ExpDepth];
   int  exp_wr = 0;
   int  exp_rd = 0;
   int  mismatches = 0;
   int  gap_pct = 0;
   int  stall_pct = 0;
   int  hold_cycles = 0;

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // weighted history sum, oldest weight 1
   function automatic void history_weights(output int s, output int w);
      s = 0;
      w = 0;
      for (int i = 0; i < mdl_fill; i++) begin
         s += int'(mdl_hist[i]) * (i + 1);
         w += i + 1;
      end
   endfunction

   task automatic predict_limit(input logic [6:0] temp, input logic ok);
      limit_result_type r;
      int s, w, latest, over, step, nxt, e, d, err, mag;
      logic braked;
      r.change = 1'b0;
      r.action = tplr_pkg::ACT_IDLE;
      if (ok && mdl_mode == tplr_pkg::MODE_MAX) begin
         r.action = tplr_pkg::ACT_MAX;
         if (mdl_power != mdl_pmax) begin
            mdl_power = mdl_pmax;
            r.change = 1'b1;
         end
      end else if (ok && mdl_mode == tplr_pkg::MODE_REG) begin
         latest = int'(temp);
         over = latest - mdl_target;
         braked = 1'b0;
         // shift the sample into the history
         if (mdl_fill < tplr_pkg::HistDepth) begin
            mdl_hist[mdl_fill] = temp;
            mdl_fill++;
         end else begin
            for (int i = 0; i < tplr_pkg::HistDepth - 1; i++) mdl_hist[i] = mdl_hist[i + 1];
            mdl_hist[tplr_pkg::HistDepth - 1] = temp;
         end
         if (over >= BrakeOvershoot) begin
            step = clamp_int(over * BrakeGain, StepLo, StepHi);
            nxt = mdl_power - step;
            if (nxt < mdl_pmin) nxt = mdl_pmin;
            if (nxt < mdl_power) begin
               mdl_power = nxt;
               mdl_cool = tplr_pkg::CooldownLength;
               r.change = 1'b1;
               r.action = tplr_pkg::ACT_BRAKE;
               braked = 1'b1;
            end
         end
         if (!braked) begin
            if (mdl_fill < tplr_pkg::MinSamples) begin
               r.action = tplr_pkg::ACT_FEW;
            end else if (mdl_cool > 0) begin
               mdl_cool--;
               r.action = tplr_pkg::ACT_COOL;
            end else begin
               history_weights(s, w);
               d = 2 * w;
               e = (latest * w > s) ? s + latest * w : 2 * s;
               err = e - mdl_target * d;
               mag = err < 0 ? -err : err;
               if (2 * mag <= 3 * d) begin
                  r.action = tplr_pkg::ACT_DEAD;
               end else begin
                  step = clamp_int((5 * mag) / (2 * d), StepLo, StepHi);
                  nxt = err > 0 ? mdl_power - step : mdl_power + step;
                  if (nxt > mdl_pmax) nxt = mdl_pmax;
                  if (nxt < mdl_pmin) nxt = mdl_pmin;
                  if (nxt == mdl_power) begin
                     r.action = tplr_pkg::ACT_CLAMP;
                  end else begin
                     mdl_power = nxt;
                     mdl_cool = tplr_pkg::CooldownLength;
                     r.change = 1'b1;
                     r.action = tplr_pkg::ACT_STEP;
                  end
               end
            end
         end
      end
      history_weights(s, w);
      r.power = mdl_power[9:0];
      r.avg = (w > 0) ? 7'(s / w) : 7'd0;
      exp_q[exp_wr[10:0]] = r;
      exp_wr++;
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Check each response against the oldest expectation
   always @(posedge clock) begin
      limit_result_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_wr == exp_rd) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response tdata=%h tuser=%h", rsp_tdata, rsp_tuser);
         end else begin
            x = exp_q[exp_rd[10:0]];
            exp_rd++;
            if (rsp_tdata[0] !== x.change || rsp_tdata[10:1] !== x.power
                || rsp_tdata[13:11] !== x.action || rsp_tuser !== x.avg) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch chg/pwr/act/avg: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           x.change, x.power, x.action, x.avg, rsp_tdata[0],
                           rsp_tdata[10:1], rsp_tdata[13:11], rsp_tuser);
            end
         end
      end
   end

   // Send one request; valid stays high across back-to-back requests
   task automatic send_tick(input logic [6:0] temp, input logic ok);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, temp};
      req_tuser <= ok;
      do @(posedge clock); while (!req_tready);
      predict_limit(temp, ok);
   endtask

   // Drop valid, wait for every response, then let the block settle
   task automatic drain;
      req_tvalid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
      csr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_en <= 1'b0;
      case (idx)
         tplr_pkg::REG_MODE: begin
            mdl_mode = val[1:0];
            mdl_fill = 0;
            mdl_cool = 0;
         end
         tplr_pkg::REG_TARGET: begin
            mdl_target = int'(val[6:0]);
            mdl_fill = 0;
            mdl_cool = 0;
         end
         tplr_pkg::REG_PMIN: mdl_pmin = int'(val);
         tplr_pkg::REG_PMAX: mdl_pmax = int'(val);
         tplr_pkg::REG_INIT: mdl_power = int'(val);
         default: ;
      endcase
   endtask

   task automatic test_off_mode;
      send_tick(7'd0, 1'b1);
      send_tick(7'd127, 1'b1);
      send_tick(7'd90, 1'b0);
      drain();
      write_reg(tplr_pkg::REG_MODE, 10'(MODE_SPARE));
      send_tick(7'd127, 1'b1);
      send_tick(7'd55, 1'b1);
      drain();
   endtask

   task automatic test_max_mode;
      write_reg(tplr_pkg::REG_PMAX, 10'd1023);
      write_reg(tplr_pkg::REG_MODE, 10'(tplr_pkg::MODE_MAX));
      send_tick(7'd40, 1'b1);    // moves to maximum
      send_tick(7'd41, 1'b1);    // already at maximum
      send_tick(7'd42, 1'b0);
      drain();
      // ignored indexes must leave everything alone
      write_reg(REG_VOID_LO, 10'h3ff);
      write_reg(REG_VOID_HI, 10'h3ff);
      send_tick(7'd43, 1'b1);
      drain();
   endtask

   task automatic test_regulate_directed;
      write_reg(tplr_pkg::REG_PMIN, 10'd0);
      write_reg(tplr_pkg::REG_PMAX, 10'd1023);
      write_reg(tplr_pkg::REG_INIT, 10'd500);
      write_reg(tplr_pkg::REG_TARGET, 10'd70);
      write_reg(tplr_pkg::REG_MODE, 10'(tplr_pkg::MODE_REG));
      send_tick(7'd70, 1'b1);    // few samples
      send_tick(7'd71, 1'b1);
      send_tick(7'd99, 1'b0);    // ignored reading
      send_tick(7'd70, 1'b1);    // deadband
      send_tick(7'd40, 1'b1);    // step up
      send_tick(7'd40, 1'b1);    // cooldown
      send_tick(7'd40, 1'b1);
      send_tick(7'd40, 1'b1);    // step again
      send_tick(7'd127, 1'b1);   // brake
      send_tick(7'd0, 1'b1);
      drain();
      // brake skipped at the floor, then clamp with no change
      write_reg(tplr_pkg::REG_PMIN, 10'd500);
      write_reg(tplr_pkg::REG_INIT, 10'd500);
      write_reg(tplr_pkg::REG_MODE, 10'(tplr_pkg::MODE_REG));
      repeat (5) send_tick(7'd100, 1'b1);
      drain();
      // inverted range: the minimum wins
      write_reg(tplr_pkg::REG_PMIN, 10'd600);
      write_reg(tplr_pkg::REG_PMAX, 10'd300);
      write_reg(tplr_pkg::REG_TARGET, 10'd0);
      repeat (4) send_tick(7'd0, 1'b1);
      send_tick(7'd5, 1'b1);
      drain();
      write_reg(tplr_pkg::REG_TARGET, 10'd127);
      write_reg(tplr_pkg::REG_PMIN, 10'd0);
      write_reg(tplr_pkg::REG_PMAX, 10'd1023);
      repeat (4) send_tick(7'd0, 1'b1);
      drain();
   endtask

   // Random settings, then ticks that mostly hover around the target
   task automatic test_random_phase(input int n);
      int t;
      write_reg(tplr_pkg::REG_PMIN, ($urandom_range(3) == 0) ? 10'($urandom)
                                                             : 10'($urandom_range(200)));
      write_reg(tplr_pkg::REG_PMAX, ($urandom_range(3) == 0) ? 10'($urandom)
                                                             : 10'($urandom_range(1023, 600)));
      write_reg(tplr_pkg::REG_INIT, 10'($urandom));
      write_reg(tplr_pkg::REG_TARGET, ($urandom_range(7) == 0) ? 10'($urandom_range(127))
                                                               : 10'($urandom_range(90, 40)));
      case ($urandom_range(9))
         0: write_reg(tplr_pkg::REG_MODE, 10'(tplr_pkg::MODE_MAX));
         1: write_reg(tplr_pkg::REG_MODE,
                      ($urandom_range(1) == 0) ? 10'(MODE_OFF) : 10'(MODE_SPARE));
         default: write_reg(tplr_pkg::REG_MODE, 10'(tplr_pkg::MODE_REG));
      endcase
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) t = $urandom_range(127);
         else t = clamp_int(mdl_target + int'($urandom_range(16)) - 8, 0, 127);
         send_tick(7'(t), $urandom_range(9) != 0);
      end
      drain();
   endtask

   task automatic test_random(input int gap, input int stall, input int phases);
      gap_pct = gap;
      stall_pct = stall;
      for (int p = 0; p < phases; p++) test_random_phase($urandom_range(30, 70));
   endtask

   // Hold the receiver off while requests keep coming, so the input backs up
   task automatic test_backpressure;
      gap_pct = 0;
      stall_pct = 0;
      write_reg(tplr_pkg::REG_MODE, 10'(tplr_pkg::MODE_REG));
      hold_cycles <= 400;
      for (int i = 0; i < 30; i++) send_tick(7'($urandom_range(127)), 1'b1);
      drain();
   endtask

   initial begin
      mdl_mode = MODE_OFF;
      mdl_target = 70;
      mdl_pmin = 100;
      mdl_pmax = 400;
      mdl_power = 150;
      mdl_fill = 0;
      mdl_cool = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (SettleCycles) @(posedge clock);
      test_off_mode();
      test_max_mode();
      test_regulate_directed();
      test_random(32, 78, 10);
      test_random(78, 32, 10);
      test_random(0, 0, 10);
      test_backpressure();
      if (mismatches == 0 && exp_wr == exp_rd) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
